FILE: sv/smu_pkg.sv
`timescale 1ns / 1ps

package smu_pkg;

   localparam int FUNC_W     = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [FUNC_W-1:0] FUNC_SPIN     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_NEIGHBOR = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEGREE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TABLE    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 3'd4;

   localparam logic REG_COUPLING      = 1'b0;
   localparam logic REG_CRYSTAL_FIELD = 1'b1;

   localparam logic signed [15:0] COUPLING_RESET      = 16'sd256;
   localparam logic signed [15:0] CRYSTAL_FIELD_RESET = 16'sd0;

   localparam int TABLE_DEPTH = 315;
   localparam int TABLE_AW    = 9;
   localparam int RHO_STRIDE  = 105;
   localparam int DS_STRIDE   = 21;
   localparam int NN_RANGE    = 10;

   typedef struct packed {
      logic clear;
      logic accept;
      logic load;
      logic sum_run;
      logic prop;
      logic mul;
      logic dec;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_update;
      logic sum_done;
   } status_type;

endpackage

FILE: sv/smu_ctrl.sv
`timescale 1ns / 1ps

module smu_ctrl
   import smu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_LOAD  = 7'b0000100,
      S_SUM   = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_DEC   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = status.is_update ? S_LOAD : S_OUT;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum_run = 1'b1;
            if (status.sum_done) begin
               cmd.prop = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.dec  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/smu_datapath.sv
`timescale 1ns / 1ps

module smu_datapath
   import smu_pkg::*;
#(
   parameter int NUM_SITES  = 1024,
   parameter int MAX_DEGREE = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [FUNC_W-1:0]      req_tuser,
   input  logic signed [15:0]     coupling,
   input  logic signed [15:0]     crystal_field,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int SITE_AW  = $clog2(NUM_SITES);
   localparam int NB_DEPTH = NUM_SITES * MAX_DEGREE;
   localparam int NB_AW    = $clog2(NB_DEPTH);
   localparam int CNT_W    = $clog2(MAX_DEGREE + 1);
   localparam int ACC_W    = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

   // input fields
   logic [9:0]          f_site;
   logic [3:0]          f_slot;
   logic [9:0]          f_nb;
   logic [1:0]          f_spin;
   logic [3:0]          f_deg;
   logic [TABLE_AW-1:0] f_tix;
   logic [15:0]         f_prob;
   logic                f_up;
   logic [15:0]         f_rnd;

   assign f_site = req_tdata[9:0];
   assign f_slot = req_tdata[13:10];
   assign f_nb   = req_tdata[23:14];
   assign f_spin = req_tdata[25:24];
   assign f_deg  = req_tdata[29:26];
   assign f_tix  = req_tdata[38:30];
   assign f_prob = req_tdata[54:39];
   assign f_up   = req_tdata[55];
   assign f_rnd  = req_tdata[71:56];

   logic               site_ok, slot_ok, tix_ok;
   logic [SITE_AW-1:0] site_addr;
   logic [NB_AW-1:0]   nb_wr_addr;

   assign site_ok    = 32'(f_site) < NUM_SITES;
   assign slot_ok    = 32'(f_slot) < MAX_DEGREE;
   assign tix_ok     = 32'(f_tix) < TABLE_DEPTH;
   assign site_addr  = SITE_AW'(f_site);
   assign nb_wr_addr = NB_AW'(32'(f_site) * MAX_DEGREE + 32'(f_slot));

   // memories
   logic [1:0]          spin_mem [NUM_SITES];
   logic [9:0]          nb_mem   [NB_DEPTH];
   logic [3:0]          deg_mem  [NUM_SITES];
   logic [15:0]         tbl_mem  [TABLE_DEPTH];

   logic                spin_we;
   logic [SITE_AW-1:0]  spin_wa, spin_ra;
   logic [1:0]          spin_wd;
   logic [1:0]          spin_rd_ff;
   logic                nb_we;
   logic [NB_AW-1:0]    nb_ra;
   logic [9:0]          nb_rd_ff;
   logic                deg_we;
   logic [SITE_AW-1:0]  deg_wa;
   logic [3:0]          deg_wd;
   logic [3:0]          deg_rd_ff;
   logic                tbl_we;
   logic [15:0]         tbl_rd_ff;

   // registers
   logic [SITE_AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [SITE_AW-1:0]       site_ff, site_in;
   logic [NB_AW-1:0]         base_ff, base_in;
   logic                     up_ff, up_in;
   logic [15:0]              rnd_ff, rnd_in;
   logic [CNT_W-1:0]         deg_ff, deg_in;
   logic signed [1:0]        old_ff, old_in;
   logic [CNT_W-1:0]         issue_cnt_ff, issue_cnt_in;
   logic                     b_valid_ff, b_valid_in;
   logic                     c_valid_ff, c_valid_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [4:0]        sum_ff, sum_in;
   logic signed [1:0]        new_ff, new_in;
   logic signed [2:0]        ds_ff, ds_in;
   logic signed [1:0]        dr_ff, dr_in;
   logic signed [5:0]        dssum_ff, dssum_in;
   logic [TABLE_AW-1:0]      idx_ff, idx_in;
   logic signed [20:0]       prod_ff, prod_in;
   logic signed [16:0]       muterm_ff, muterm_in;
   logic                     res_acc_ff, res_acc_in;
   logic signed [20:0]       res_de_ff, res_de_in;
   logic signed [2:0]        res_dm_ff, res_dm_in;
   logic signed [1:0]        res_dr_ff, res_dr_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // combinational terms
   logic                     issue, nb_ok;
   logic signed [4:0]        sat_sum;
   logic signed [1:0]        ns_w;
   logic signed [2:0]        ds_w;
   logic signed [1:0]        dr_w;
   logic signed [21:0]       de_w;
   logic                     accept_now;

   assign issue = cmd.sum_run && (issue_cnt_ff != deg_ff);
   assign nb_ok = 32'(nb_rd_ff) < NUM_SITES;

   assign status.clear_done = (clr_cnt_ff == SITE_AW'(NUM_SITES - 1));
   assign status.is_update  = (req_tuser == FUNC_UPDATE) && site_ok;
   assign status.sum_done   = (issue_cnt_ff == deg_ff) && !b_valid_ff && !c_valid_ff;

   // memory ports
   assign spin_we = (cmd.accept && req_tuser == FUNC_SPIN && site_ok) || (cmd.dec && accept_now);
   assign spin_wa = cmd.dec ? site_ff : site_addr;
   assign spin_wd = cmd.dec ? new_ff : ((f_spin == 2'b10) ? 2'b11 : f_spin);
   assign spin_ra = cmd.accept ? site_addr : SITE_AW'(nb_rd_ff);

   assign nb_we = cmd.accept && req_tuser == FUNC_NEIGHBOR && site_ok && slot_ok;
   assign nb_ra = base_ff + NB_AW'(issue_cnt_ff);

   assign deg_we = cmd.clear || (cmd.accept && req_tuser == FUNC_DEGREE && site_ok);
   assign deg_wa = cmd.clear ? clr_cnt_ff : site_addr;
   assign deg_wd = cmd.clear ? 4'd0 : f_deg;

   assign tbl_we = cmd.accept && req_tuser == FUNC_TABLE && tix_ok;

   always_ff @(posedge clock) begin
      if (spin_we) begin
         spin_mem[spin_wa] <= spin_wd;
      end
      spin_rd_ff <= spin_mem[spin_ra];
   end

   always_ff @(posedge clock) begin
      if (nb_we) begin
         nb_mem[nb_wr_addr] <= f_nb;
      end
      nb_rd_ff <= nb_mem[nb_ra];
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wa] <= deg_wd;
      end
      deg_rd_ff <= deg_mem[site_addr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[f_tix] <= f_prob;
      end
      tbl_rd_ff <= tbl_mem[idx_ff];
   end

   // proposal terms
   always_comb begin
      if (acc_ff > ACC_W'(NN_RANGE)) begin
         sat_sum = 5'(NN_RANGE);
      end else if (acc_ff < ACC_W'(-NN_RANGE)) begin
         sat_sum = 5'(-NN_RANGE);
      end else begin
         sat_sum = 5'(acc_ff);
      end

      case ({old_ff, up_ff})
         3'b111:  ns_w = 2'sb00;
         3'b001:  ns_w = 2'sb01;
         3'b011:  ns_w = 2'sb11;
         3'b110:  ns_w = 2'sb01;
         3'b000:  ns_w = 2'sb11;
         3'b010:  ns_w = 2'sb00;
         default: ns_w = 2'sb00;
      endcase

      ds_w = 3'(ns_w) - 3'(old_ff);
      dr_w = $signed({1'b0, ns_w != 2'sb00}) - $signed({1'b0, old_ff != 2'sb00});
   end

   assign de_w       = 22'(muterm_ff) - 22'(prod_ff);
   assign accept_now = de_w[21] || (de_w == 22'sd0) || (tbl_rd_ff > rnd_ff);

   always_comb begin
      clr_cnt_in   = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      site_in      = site_ff;
      base_in      = base_ff;
      up_in        = up_ff;
      rnd_in       = rnd_ff;
      deg_in       = deg_ff;
      old_in       = old_ff;
      issue_cnt_in = issue_cnt_ff;
      b_valid_in   = issue;
      c_valid_in   = b_valid_ff && nb_ok;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      new_in       = new_ff;
      ds_in        = ds_ff;
      dr_in        = dr_ff;
      dssum_in     = dssum_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      muterm_in    = muterm_ff;
      res_acc_in   = res_acc_ff;
      res_de_in    = res_de_ff;
      res_dm_in    = res_dm_ff;
      res_dr_in    = res_dr_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.accept) begin
         site_in    = site_addr;
         base_in    = NB_AW'(32'(f_site) * MAX_DEGREE);
         up_in      = f_up;
         rnd_in     = f_rnd;
         old_in     = '0;
         sum_in     = '0;
         new_in     = '0;
         res_acc_in = 1'b0;
         res_de_in  = '0;
         res_dm_in  = '0;
         res_dr_in  = '0;
      end

      if (cmd.load) begin
         deg_in       = (32'(deg_rd_ff) > MAX_DEGREE) ? CNT_W'(MAX_DEGREE) : CNT_W'(deg_rd_ff);
         old_in       = $signed(spin_rd_ff);
         issue_cnt_in = '0;
         acc_in       = '0;
      end

      if (issue) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end

      if (c_valid_ff) begin
         acc_in = acc_ff + ACC_W'($signed(spin_rd_ff));
      end

      if (cmd.prop) begin
         sum_in   = sat_sum;
         new_in   = ns_w;
         ds_in    = ds_w;
         dr_in    = dr_w;
         dssum_in = 6'(ds_w) * 6'(sat_sum);
         idx_in   = TABLE_AW'((32'(dr_w) + 1) * RHO_STRIDE + (32'(ds_w) + 2) * DS_STRIDE
                              + 32'(sat_sum) + NN_RANGE);
      end

      if (cmd.mul) begin
         prod_in = 21'(coupling) * 21'(dssum_ff);
         case (dr_ff)
            2'sb01:  muterm_in = 17'(crystal_field);
            2'sb11:  muterm_in = -17'(crystal_field);
            default: muterm_in = '0;
         endcase
      end

      if (cmd.dec && accept_now) begin
         res_acc_in = 1'b1;
         res_de_in  = 21'(de_w);
         res_dm_in  = ds_ff;
         res_dr_in  = dr_ff;
      end

      if (cmd.out_load) begin
         rsp_data_in = {4'b0000, res_dr_ff, res_dm_ff, res_de_ff, sum_ff, new_ff, old_ff,
                        res_acc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      site_ff      <= site_in;
      base_ff      <= base_in;
      up_ff        <= up_in;
      rnd_ff       <= rnd_in;
      deg_ff       <= deg_in;
      old_ff       <= old_in;
      issue_cnt_ff <= issue_cnt_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      new_ff       <= new_in;
      ds_ff        <= ds_in;
      dr_ff        <= dr_in;
      dssum_ff     <= dssum_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      muterm_ff    <= muterm_in;
      res_acc_ff   <= res_acc_in;
      res_de_ff    <= res_de_in;
      res_dm_ff    <= res_dm_in;
      res_dr_ff    <= res_dr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

FILE: sv/spin_one_metropolis_update_core.sv
// Update: the result follows a walk over the site's d neighbors through the neighbor and spin
// memories, d being the site's degree (capped at MAX_DEGREE).
// One request at a time: a new one is taken only in idle, once the last response is loaded.
// Reset: synchronous; the degree memory is cleared in a pass over all NUM_SITES sites during
// which no item is taken; registers return to coupling 256 and crystal field 0.
`timescale 1ns / 1ps

module spin_one_metropolis_update_core
   import smu_pkg::*;
#(
   parameter int NUM_SITES  = 1024,
   parameter int MAX_DEGREE = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // site, slot, neighbor_site, spin_value, degree, table_index, probability,
   // step_up, random
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted, old_spin, proposed_spin, neighbor_sum, delta_energy, delta_magn,
   // delta_rho, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   logic signed [15:0] coupling_ff, coupling_in;
   logic signed [15:0] crystal_field_ff, crystal_field_in;
   logic               csr_write;
   logic               csr_index;
   cmd_type            cmd;
   status_type         status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      coupling_in      = coupling_ff;
      crystal_field_in = crystal_field_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_COUPLING:      coupling_in      = csr_pwdata[15:0];
            REG_CRYSTAL_FIELD: crystal_field_in = csr_pwdata[15:0];
            default:           coupling_in      = coupling_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COUPLING:      csr_prdata = {16'h0000, coupling_ff};
         REG_CRYSTAL_FIELD: csr_prdata = {16'h0000, crystal_field_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff      <= COUPLING_RESET;
         crystal_field_ff <= CRYSTAL_FIELD_RESET;
      end else begin
         coupling_ff      <= coupling_in;
         crystal_field_ff <= crystal_field_in;
      end
   end

   smu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smu_datapath #(
      .NUM_SITES  (NUM_SITES),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .coupling      (coupling_ff),
      .crystal_field (crystal_field_ff),
      .cmd           (cmd),
      .status        (status),
      .rsp_tdata     (rsp_tdata)
   );

endmodule
